[sv/slr_pkg.sv]
// Shared types and constants for the styled line rasterizer.
// Used by every module of the block; depends on nothing.
package slr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int CFG_BITS   = 8;
    localparam int STYLE_BITS = 2;
    localparam int PAT_BITS   = CFG_BITS + 1;
    localparam int IDX_BITS   = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [STYLE_BITS-1:0] STYLE_SOLID  = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_DOTTED = 2'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 2'd2;

    localparam logic [IDX_BITS-1:0] REG_LINE_STYLE  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_DASH_LENGTH = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_GAP_LENGTH  = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_DOT_PERIOD  = 2'd3;

    localparam logic [STYLE_BITS-1:0] LINE_STYLE_RST  = STYLE_SOLID;
    localparam logic [CFG_BITS-1:0]   DASH_LENGTH_RST = 8'd8;
    localparam logic [CFG_BITS-1:0]   GAP_LENGTH_RST  = 8'd12;
    localparam logic [CFG_BITS-1:0]   DOT_PERIOD_RST  = 8'd8;

    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         drawn;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        logic [STYLE_BITS-1:0] line_style;
        logic [CFG_BITS-1:0]   dash_length;
        logic [CFG_BITS-1:0]   gap_length;
        logic [CFG_BITS-1:0]   dot_period;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic step;
    } cmd_t;

endpackage

[sv/styled_line_rasterizer_top.sv]
// Top level of the styled line rasterizer: input register, configuration
// registers, line stepper, style pattern and output register.
// Depends on slr_pkg, slr_stepper and slr_pattern.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     slr_pkg::in_item_t
// out      output     out_valid / out_stall   slr_pkg::out_item_t
// cfg      input      cfg_we (no wait)        cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; a step item passes through
// the input register and then the result register, where its point is held and
// can be taken at the next edge. The stepper and pattern state update once per item.
// Reset clears all line state and loads the register defaults.
// A stalled output holds its point, and a step item then waits in the input
// register; start items and steps while idle pass through regardless.
module styled_line_rasterizer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  slr_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output slr_pkg::out_item_t               out_item,
    input  logic                             cfg_we,
    input  logic [slr_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [slr_pkg::CFG_BITS-1:0]     cfg_data
);

    slr_pkg::cfg_t      cfg_reg;
    slr_pkg::cfg_t      cfg_next;
    slr_pkg::in_item_t  item_reg;
    logic               item_valid_reg;
    logic               item_valid_next;
    slr_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    slr_pkg::cmd_t      cmd;

    logic                                  active;
    logic signed [slr_pkg::COORD_BITS-1:0] pixel_x;
    logic signed [slr_pkg::COORD_BITS-1:0] pixel_y;
    logic                                  last;
    logic                                  drawn;
    logic                                  is_start;
    logic                                  is_step;
    logic                                  advance;
    logic                                  take_in;

    assign is_start = (item_reg.op == slr_pkg::OP_START);
    assign is_step  = (item_reg.op == slr_pkg::OP_STEP) && active;
    assign advance  = item_valid_reg && (!is_step || !out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    assign cmd.start = advance && is_start;
    assign cmd.step  = advance && is_step;

    assign item_valid_next = take_in ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    assign out_valid_next  = cmd.step ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                slr_pkg::REG_LINE_STYLE:
                begin
                    cfg_next.line_style = cfg_data[slr_pkg::STYLE_BITS-1:0];
                end
                slr_pkg::REG_DASH_LENGTH:
                begin
                    cfg_next.dash_length = cfg_data;
                end
                slr_pkg::REG_GAP_LENGTH:
                begin
                    cfg_next.gap_length = cfg_data;
                end
                slr_pkg::REG_DOT_PERIOD:
                begin
                    cfg_next.dot_period = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    slr_stepper u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item    (item_reg),
        .active  (active),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .last    (last)
    );

    slr_pattern u_pattern (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .drawn (drawn)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_style  <= slr_pkg::LINE_STYLE_RST;
            cfg_reg.dash_length <= slr_pkg::DASH_LENGTH_RST;
            cfg_reg.gap_length  <= slr_pkg::GAP_LENGTH_RST;
            cfg_reg.dot_period  <= slr_pkg::DOT_PERIOD_RST;
            item_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg <= in_item;
        end
        if (cmd.step)
        begin
            out_reg.pixel_x <= pixel_x;
            out_reg.pixel_y <= pixel_y;
            out_reg.drawn   <= drawn;
            out_reg.last    <= last;
        end
    end

endmodule

[sv/slr_pattern.sv]
// Line style pattern counter and drawn flag for the styled line rasterizer.
// Depends on slr_pkg.
module slr_pattern (
    input  logic          clk,
    input  logic          rst_n,
    input  slr_pkg::cfg_t cfg,
    input  slr_pkg::cmd_t cmd,
    output logic          drawn
);

    logic [slr_pkg::PAT_BITS-1:0] count_reg;
    logic [slr_pkg::PAT_BITS-1:0] count_next;
    logic [slr_pkg::PAT_BITS-1:0] period;
    logic [slr_pkg::PAT_BITS:0]   count_inc;
    logic                         counting;

    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        period   = '0;
        counting = 1'b0;
        drawn    = 1'b1;
        case (cfg.line_style)
            slr_pkg::STYLE_DOTTED:
            begin
                counting = 1'b1;
                period   = {1'b0, cfg.dot_period};
                drawn    = (count_reg == '0);
            end
            slr_pkg::STYLE_DASHED:
            begin
                counting = 1'b1;
                period   = {1'b0, cfg.dash_length} + {1'b0, cfg.gap_length};
                drawn    = (count_reg < {1'b0, cfg.dash_length});
            end
            default:
            begin
                counting = 1'b0;
                drawn    = 1'b1;
            end
        endcase
        if (period == '0)
        begin
            period = {{(slr_pkg::PAT_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.start)
        begin
            count_next = '0;
        end
        else if (cmd.step && counting)
        begin
            if (count_inc >= {1'b0, period})
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_inc[slr_pkg::PAT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[sv/slr_stepper.sv]
// Bresenham line state: setup on a start item and one point per step item.
// Depends on slr_pkg.
module slr_stepper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  slr_pkg::cmd_t                        cmd,
    input  slr_pkg::in_item_t                    item,
    output logic                                 active,
    output logic signed [slr_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [slr_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                 last
);

    localparam int C = slr_pkg::COORD_BITS;
    localparam int E = slr_pkg::ERR_BITS;

    logic                active_reg;
    logic                active_next;
    logic signed [C-1:0] cur_x_reg;
    logic signed [C-1:0] cur_x_next;
    logic signed [C-1:0] cur_y_reg;
    logic signed [C-1:0] cur_y_next;
    logic signed [E-1:0] err_reg;
    logic signed [E-1:0] err_next;
    logic [C-1:0]        long_reg;
    logic [C-1:0]        long_next;
    logic [C-1:0]        short_reg;
    logic [C-1:0]        short_next;
    logic signed [1:0]   step_x_reg;
    logic signed [1:0]   step_x_next;
    logic signed [1:0]   step_y_reg;
    logic signed [1:0]   step_y_next;
    logic                swapped_reg;
    logic                swapped_next;
    logic [C-1:0]        steps_left_reg;
    logic [C-1:0]        steps_left_next;

    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic [C-1:0]        adx;
    logic [C-1:0]        ady;
    logic                swap_new;
    logic [C-1:0]        long_new;
    logic [C-1:0]        short_new;
    logic signed [C-1:0] inc_x;
    logic signed [C-1:0] inc_y;
    logic signed [E-1:0] two_short;
    logic signed [E-1:0] two_long;
    logic signed [E-1:0] err_adj;

    assign dx  = {item.end_x[C-1], item.end_x} - {item.start_x[C-1], item.start_x};
    assign dy  = {item.end_y[C-1], item.end_y} - {item.start_y[C-1], item.start_y};
    assign adx = dx[C] ? C'(-dx) : dx[C-1:0];
    assign ady = dy[C] ? C'(-dy) : dy[C-1:0];

    assign swap_new  = (ady > adx);
    assign long_new  = swap_new ? ady : adx;
    assign short_new = swap_new ? adx : ady;

    assign inc_x     = {{(C-2){step_x_reg[1]}}, step_x_reg};
    assign inc_y     = {{(C-2){step_y_reg[1]}}, step_y_reg};
    assign two_short = $signed({2'b00, short_reg, 1'b0});
    assign two_long  = $signed({2'b00, long_reg, 1'b0});
    assign err_adj   = err_reg[E-1] ? err_reg : err_reg - two_long;

    assign active  = active_reg;
    assign pixel_x = cur_x_reg;
    assign pixel_y = cur_y_reg;
    assign last    = (steps_left_reg == '0);

    always_comb
    begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_next        = err_reg;
        long_next       = long_reg;
        short_next      = short_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        swapped_next    = swapped_reg;
        steps_left_next = steps_left_reg;
        if (cmd.start)
        begin
            active_next     = 1'b1;
            cur_x_next      = item.start_x;
            cur_y_next      = item.start_y;
            long_next       = long_new;
            short_next      = short_new;
            swapped_next    = swap_new;
            steps_left_next = long_new;
            step_x_next     = dx[C] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
            step_y_next     = dy[C] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
            err_next        = $signed({2'b00, short_new, 1'b0})
                              - $signed({3'b000, long_new});
        end
        else if (cmd.step)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (!err_reg[E-1])
                begin
                    if (swapped_reg)
                    begin
                        cur_x_next = cur_x_reg + inc_x;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + inc_y;
                    end
                end
                if (swapped_reg)
                begin
                    cur_y_next = (!err_reg[E-1] && !swapped_reg) ? cur_y_reg : cur_y_reg + inc_y;
                end
                else
                begin
                    cur_x_next = cur_x_reg + inc_x;
                end
                err_next        = err_adj + two_short;
                steps_left_next = steps_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            err_reg        <= '0;
            long_reg       <= '0;
            short_reg      <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            swapped_reg    <= 1'b0;
            steps_left_reg <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            err_reg        <= err_next;
            long_reg       <= long_next;
            short_reg      <= short_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            swapped_reg    <= swapped_next;
            steps_left_reg <= steps_left_next;
        end
    end

endmodule

[tb/styled_line_rasterizer_top_test.sv]
// Self-checking testbench for styled_line_rasterizer_top: drives start and step items,
// predicts every point with its own line and style model, and checks each result.
// Depends on slr_pkg and the RTL of the styled line rasterizer.
`timescale 1ns / 1ps

module styled_line_rasterizer_top_test;

    localparam int COORD_W = slr_pkg::COORD_BITS;
    localparam int ERR_W   = slr_pkg::ERR_BITS;
    localparam int ITEM_W  = $bits(slr_pkg::in_item_t);
    localparam int SPARE_W = slr_pkg::CFG_BITS - slr_pkg::STYLE_BITS;
    localparam logic [slr_pkg::STYLE_BITS-1:0] STYLE_UNDEF = 2'd3;
    localparam int MAX_WAIT     = 17;
    localparam int DRAIN_CYCLES = 8;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    slr_pkg::in_item_t             in_item   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    slr_pkg::out_item_t            out_item;
    logic                          cfg_we    = 1'b0;
    logic [slr_pkg::IDX_BITS-1:0]  cfg_index = '0;
    logic [slr_pkg::CFG_BITS-1:0]  cfg_data  = '0;

    logic                            line_active   = 1'b0;
    logic signed [COORD_W-1:0]       line_x        = '0;
    logic signed [COORD_W-1:0]       line_y        = '0;
    logic signed [ERR_W-1:0]         line_err      = '0;
    logic [COORD_W-1:0]              major_delta   = '0;
    logic [COORD_W-1:0]              minor_delta   = '0;
    logic signed [1:0]               dir_x         = '0;
    logic signed [1:0]               dir_y         = '0;
    logic                            steep         = 1'b0;
    logic [COORD_W:0]                points_left   = '0;
    logic [slr_pkg::PAT_BITS-1:0]    pattern_phase = '0;

    logic [slr_pkg::STYLE_BITS-1:0] style_reg = slr_pkg::LINE_STYLE_RST;
    logic [slr_pkg::CFG_BITS-1:0]   dash_reg  = slr_pkg::DASH_LENGTH_RST;
    logic [slr_pkg::CFG_BITS-1:0]   gap_reg   = slr_pkg::GAP_LENGTH_RST;
    logic [slr_pkg::CFG_BITS-1:0]   dot_reg   = slr_pkg::DOT_PERIOD_RST;

    slr_pkg::out_item_t pending_pixels [$];
    int          error_count      = 0;
    int          items_sent       = 0;
    int          points_checked   = 0;
    int          settings_applied = 0;
    bit          tx_idle_on       = 1'b1;
    bit          rx_idle_on       = 1'b1;
    int unsigned hold_off_len     = 0;

    styled_line_rasterizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic style_bit();
        int unsigned period;
        logic        on;
        case (style_reg)
            slr_pkg::STYLE_DOTTED:
            begin
                period = (dot_reg == 0) ? 1 : dot_reg;
                on     = (pattern_phase == 0);
            end
            slr_pkg::STYLE_DASHED:
            begin
                period = int'(dash_reg) + int'(gap_reg);
                if (period == 0)
                begin
                    period = 1;
                end
                on = (pattern_phase < dash_reg);
            end
            default:
            begin
                return 1'b1;
            end
        endcase
        pattern_phase = pattern_phase + 1'b1;
        if (pattern_phase >= period)
        begin
            pattern_phase = '0;
        end
        return on;
    endfunction

    function automatic void load_line(input slr_pkg::in_item_t item);
        int dx;
        int dy;
        int adx;
        int ady;
        dx  = int'(item.end_x) - int'(item.start_x);
        dy  = int'(item.end_y) - int'(item.start_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        dir_x = (dx > 0) ? 2'sd1 : ((dx < 0) ? -2'sd1 : 2'sd0);
        dir_y = (dy > 0) ? 2'sd1 : ((dy < 0) ? -2'sd1 : 2'sd0);
        steep       = (ady > adx);
        major_delta = COORD_W'(steep ? ady : adx);
        minor_delta = COORD_W'(steep ? adx : ady);
        line_err    = ERR_W'(2 * int'(minor_delta) - int'(major_delta));
        line_x      = item.start_x;
        line_y      = item.start_y;
        points_left = {1'b0, major_delta};
        pattern_phase = '0;
        line_active = 1'b1;
    endfunction

    function automatic void next_pixel();
        slr_pkg::out_item_t pixel;
        if (!line_active)
        begin
            return;
        end
        pixel.pixel_x = line_x;
        pixel.pixel_y = line_y;
        pixel.last    = (points_left == 0);
        pixel.drawn   = style_bit();
        pending_pixels.push_back(pixel);
        if (pixel.last)
        begin
            line_active = 1'b0;
        end
        else
        begin
            if (line_err >= 0)
            begin
                if (steep)
                begin
                    line_x = line_x + dir_x;
                end
                else
                begin
                    line_y = line_y + dir_y;
                end
                line_err = ERR_W'(int'(line_err) - 2 * int'(major_delta));
            end
            if (steep)
            begin
                line_y = line_y + dir_y;
            end
            else
            begin
                line_x = line_x + dir_x;
            end
            line_err    = ERR_W'(int'(line_err) + 2 * int'(minor_delta));
            points_left = points_left - 1'b1;
        end
    endfunction

    function automatic void check_field(input string field, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : pixel_check
        slr_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            points_checked++;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected point (%0d, %0d)", out_item.pixel_x, out_item.pixel_y);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.pixel_x, out_item.pixel_x);
                check_field("pixel_y", want.pixel_y, out_item.pixel_y);
                check_field("drawn", want.drawn, out_item.drawn);
                check_field("last", want.last, out_item.last);
            end
        end
    end

    initial
    begin : result_sink
        int unsigned pause;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && out_valid && !out_stall)
            begin
                pause = $urandom_range(0, MAX_WAIT);
                if (pause != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_item(input slr_pkg::in_item_t item);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (item.op == slr_pkg::OP_START)
        begin
            load_line(item);
        end
        else
        begin
            next_pixel();
        end
        items_sent++;
    endtask

    task automatic send_start(input int sx, input int sy, input int ex, input int ey);
        slr_pkg::in_item_t item;
        item.op      = slr_pkg::OP_START;
        item.start_x = COORD_W'(sx);
        item.start_y = COORD_W'(sy);
        item.end_x   = COORD_W'(ex);
        item.end_y   = COORD_W'(ey);
        send_item(item);
    endtask

    task automatic send_step();
        slr_pkg::in_item_t item;
        item.op      = slr_pkg::OP_STEP;
        item.start_x = COORD_W'($urandom);
        item.start_y = COORD_W'($urandom);
        item.end_x   = COORD_W'($urandom);
        item.end_y   = COORD_W'($urandom);
        send_item(item);
    endtask

    task automatic wait_idle();
        int unsigned guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [slr_pkg::IDX_BITS-1:0] index,
                             input logic [slr_pkg::CFG_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            slr_pkg::REG_LINE_STYLE:  style_reg = data[slr_pkg::STYLE_BITS-1:0];
            slr_pkg::REG_DASH_LENGTH: dash_reg  = data;
            slr_pkg::REG_GAP_LENGTH:  gap_reg   = data;
            slr_pkg::REG_DOT_PERIOD:  dot_reg   = data;
            default:                  ;
        endcase
    endtask

    task automatic apply_settings(input slr_pkg::cfg_t setting);
        logic [SPARE_W-1:0] spare;
        spare = SPARE_W'($urandom);
        write_reg(slr_pkg::REG_LINE_STYLE, {spare, setting.line_style});
        write_reg(slr_pkg::REG_DASH_LENGTH, setting.dash_length);
        write_reg(slr_pkg::REG_GAP_LENGTH, setting.gap_length);
        write_reg(slr_pkg::REG_DOT_PERIOD, setting.dot_period);
        settings_applied++;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0:       return -2048;
            1:       return 2047;
            default: return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    task automatic send_random_burst();
        slr_pkg::in_item_t item;
        logic [ITEM_W-1:0] raw;
        int unsigned       kind;
        int unsigned       reach;
        int unsigned       points;
        int unsigned       n;
        int                sx;
        int                sy;
        int                ex;
        int                ey;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            raw  = ITEM_W'({$urandom, $urandom});
            item = raw;
            send_item(item);
            return;
        end
        reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
        sx = pick_coord();
        sy = pick_coord();
        ex = sx + int'($urandom_range(0, 2 * reach)) - int'(reach);
        ey = sy + int'($urandom_range(0, 2 * reach)) - int'(reach);
        ex = (ex < -2048) ? -2048 : ((ex > 2047) ? 2047 : ex);
        ey = (ey < -2048) ? -2048 : ((ey > 2047) ? 2047 : ey);
        points = (((ex > sx) ? ex - sx : sx - ex) > ((ey > sy) ? ey - sy : sy - ey))
                 ? ((ex > sx) ? ex - sx : sx - ex) : ((ey > sy) ? ey - sy : sy - ey);
        points = points + 1;
        if (kind == 1)
        begin
            n = $urandom_range(0, points - 1);
        end
        else if (kind == 2)
        begin
            n = points + $urandom_range(1, 2);
        end
        else
        begin
            n = points;
        end
        send_start(sx, sy, ex, ey);
        repeat (n) send_step();
    endtask

    task automatic test_directed_lines();
        send_step();
        send_start(0, 0, 0, 0);
        send_step();
        send_step();
        send_start(-2048, -2048, 2047, 2047);
        repeat (3) send_step();
        send_start(2047, 2047, -2048, -2048);
        repeat (2) send_step();
        send_start(-2048, 2047, 2047, -2048);
        send_step();
        send_start(5, 3, 2, 7);
        repeat (5) send_step();
        send_start(0, 0, 3, -1);
        repeat (4) send_step();
        wait_idle();
    endtask

    task automatic test_pattern_wrap();
        apply_settings('{slr_pkg::STYLE_DASHED, 8'd200, 8'd50, 8'd8});
        send_start(-100, 10, 0, 40);
        repeat (60) send_step();
        wait_idle();
        apply_settings('{slr_pkg::STYLE_DASHED, 8'd3, 8'd2, 8'd8});
        repeat (20) send_step();
        wait_idle();
        apply_settings('{slr_pkg::STYLE_DOTTED, 8'd3, 8'd2, 8'd255});
        repeat (10) send_step();
        wait_idle();
        apply_settings('{slr_pkg::STYLE_DOTTED, 8'd3, 8'd2, 8'd2});
        repeat (11) send_step();
        wait_idle();
    endtask

    task automatic test_random_styles();
        slr_pkg::cfg_t plan [12];
        int            target;
        plan = '{
            '{slr_pkg::STYLE_SOLID,  8'd8,   8'd12,  8'd8},
            '{slr_pkg::STYLE_DOTTED, 8'd1,   8'd0,   8'd1},
            '{slr_pkg::STYLE_DOTTED, 8'd9,   8'd4,   8'd255},
            '{slr_pkg::STYLE_DOTTED, 8'd9,   8'd4,   8'd0},
            '{slr_pkg::STYLE_DASHED, 8'd1,   8'd0,   8'd3},
            '{slr_pkg::STYLE_DASHED, 8'd255, 8'd255, 8'd3},
            '{slr_pkg::STYLE_DASHED, 8'd0,   8'd5,   8'd3},
            '{slr_pkg::STYLE_DASHED, 8'd0,   8'd0,   8'd3},
            '{slr_pkg::STYLE_DASHED, 8'd3,   8'd2,   8'd3},
            '{STYLE_UNDEF,           8'd0,   8'd0,   8'd0},
            '{slr_pkg::STYLE_DOTTED, 8'd2,   8'd255, 8'd3},
            '{slr_pkg::STYLE_DASHED, 8'd2,   8'd255, 8'd1}
        };
        foreach (plan[i])
        begin
            tx_idle_on = (i % 3) != 0;
            rx_idle_on = (i % 4) != 0;
            apply_settings(plan[i]);
            target = items_sent + 80;
            while (items_sent < target)
            begin
                send_random_burst();
            end
            wait_idle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        tx_idle_on   = 1'b0;
        hold_off_len = 60;
        send_start(300, -400, 260, -340);
        repeat (61) send_step();
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    initial
    begin : test_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_lines();
        test_pattern_wrap();
        test_random_styles();
        test_backpressure();
        wait_idle();
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected points never arrived", pending_pixels.size());
            error_count++;
        end
        $display("Sent %0d items and checked %0d points over %0d register settings.",
                 items_sent, points_checked, settings_applied);
        $display("Runs included idle gaps on both sides, a long output hold-off and restarts.");
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $error("run did not finish in time");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[styled_line_rasterizer_top.f]
sv/slr_pkg.sv
sv/slr_pattern.sv
sv/slr_stepper.sv
sv/styled_line_rasterizer_top.sv
tb/styled_line_rasterizer_top_test.sv
